@@ rtl/shpa_pkg.sv @@
// Shared types and constants for the stepped-probe hash slot allocator.
// No dependencies; regs, store and the top level refer to it by scoped names, the testbench imports it.
package shpa_pkg;

    localparam int DEF_SLOTS     = 1024;
    localparam int DEF_KEY_SPACE = 1024;

    localparam int FIELD_W  = 10;
    localparam int SIZE_W   = 11;
    localparam int TOTAL_W  = 48;
    localparam int STATUS_W = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SIZE_W-1:0]  RST_TABLE_SIZE = 11'd1024;
    localparam logic [FIELD_W-1:0] RST_PROBE_STEP = 10'd1;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_PROBE_STEP = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_DEL
    } t_state;

    typedef struct packed {
        logic occ_we;
        logic occ_wbit;
        logic key_we;
        logic key_wpresent;
    } t_store_ctl;

endpackage

@@ rtl/shpa_mod_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on shpa_pkg only through the parameters handed in.
module shpa_mod_unit #(
    parameter int DW = 10,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [VW-1:0] o_rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [VW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_num, n_num;
    logic [VW:0]     t_shift;
    logic [VW:0]     t_diff;
    logic            t_ge;

    assign t_shift = {r_rem, r_num[DW-1]};
    assign t_ge    = t_shift >= {1'b0, i_divisor};
    assign t_diff  = t_shift - {1'b0, i_divisor};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_num = r_num;
        if (i_start) begin
            n_cnt = CNTW'(DW);
            n_rem = '0;
            n_num = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_num = r_num << 1;
            n_rem = t_ge ? t_diff[VW-1:0] : t_shift[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_num <= n_num;
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

@@ rtl/shpa_regs.sv @@
// APB configuration registers: table size and probe step.
// Depends on shpa_pkg for widths, reset values and register indexes.
module shpa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shpa_pkg::APB_AW-1:0]   paddr,
    input  logic [shpa_pkg::APB_DW-1:0]   pwdata,
    output logic [shpa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [shpa_pkg::SIZE_W-1:0]   o_table_size,
    output logic [shpa_pkg::FIELD_W-1:0]  o_probe_step
);

    localparam int AW = shpa_pkg::APB_DW;
    localparam int SW = shpa_pkg::SIZE_W;
    localparam int FW = shpa_pkg::FIELD_W;

    logic [SW-1:0] r_table_size;
    logic [FW-1:0] r_probe_step;
    logic          wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= shpa_pkg::RST_TABLE_SIZE;
            r_probe_step <= shpa_pkg::RST_PROBE_STEP;
        end else if (wr) begin
            if (paddr[2] == shpa_pkg::REG_TABLE_SIZE) begin
                r_table_size <= pwdata[SW-1:0];
            end else begin
                r_probe_step <= pwdata[FW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == shpa_pkg::REG_PROBE_STEP) ? AW'(r_probe_step)
                                                           : AW'(r_table_size);
    assign o_table_size = r_table_size;
    assign o_probe_step = r_probe_step;

endmodule

@@ rtl/shpa_store.sv @@
// Occupancy map and key-to-slot memories, registered synchronous reads.
// Depends on shpa_pkg for the write control struct.
module shpa_store #(
    parameter int SLOTS     = shpa_pkg::DEF_SLOTS,
    parameter int KEY_SPACE = shpa_pkg::DEF_KEY_SPACE
) (
    input  logic                    i_clk,
    input  shpa_pkg::t_store_ctl    i_ctl,
    input  logic [$clog2(SLOTS)-1:0]     i_occ_waddr,
    input  logic [$clog2(SLOTS)-1:0]     i_occ_raddr,
    output logic                         o_occ_rdata,
    input  logic [$clog2(KEY_SPACE)-1:0] i_key_waddr,
    input  logic [$clog2(KEY_SPACE)-1:0] i_key_raddr,
    input  logic [$clog2(SLOTS)-1:0]     i_key_wslot,
    output logic                         o_key_rpresent,
    output logic [$clog2(SLOTS)-1:0]     o_key_rslot
);

    localparam int SW = $clog2(SLOTS);

    logic          occ_mem [SLOTS];
    logic [SW:0]   key_mem [KEY_SPACE];
    logic          r_occ_rd;
    logic [SW:0]   r_key_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.occ_we) begin
            occ_mem[i_occ_waddr] <= i_ctl.occ_wbit;
        end
        r_occ_rd <= occ_mem[i_occ_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            key_mem[i_key_waddr] <= {i_ctl.key_wpresent, i_key_wslot};
        end
        r_key_rd <= key_mem[i_key_raddr];
    end

    assign o_occ_rdata    = r_occ_rd;
    assign o_key_rpresent = r_key_rd[SW];
    assign o_key_rslot    = r_key_rd[SW-1:0];

endmodule

@@ rtl/stepped_probe_hash_slot_allocator.sv @@
// Top level of the stepped-probe hash slot allocator: control sequencer,
// remainder units, configuration registers and the slot/key memories.
// Depends on shpa_pkg, shpa_mod_unit, shpa_regs and shpa_store.
//
// Usage: raise start with i_op, i_key_id and i_home_slot while busy is low;
// the beat is taken at that edge. Exactly one result beat follows, shown for
// one cycle with o_valid high; the receiver cannot stall it.
// An item first reduces home slot and step through two bit-serial
// remainder units (the key is reduced by a reciprocal multiply meanwhile),
// then an insert reads the occupancy memory once per probed slot, one probe
// per cycle, the next address issued while the previous read returns. The
// next item may start in the cycle o_valid is shown.
// After reset a clearing pass walks both memories with busy high; APB
// writes are taken at all times but must only change the registers while
// busy is low.
module stepped_probe_hash_slot_allocator #(
    parameter int SLOTS     = shpa_pkg::DEF_SLOTS,
    parameter int KEY_SPACE = shpa_pkg::DEF_KEY_SPACE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [shpa_pkg::FIELD_W-1:0]    i_key_id,
    input  logic [shpa_pkg::FIELD_W-1:0]    i_home_slot,
    output logic                            o_valid,
    output logic [shpa_pkg::FIELD_W-1:0]    o_slot,
    output logic [shpa_pkg::FIELD_W-1:0]    o_skipped_probes,
    output logic [shpa_pkg::TOTAL_W-1:0]    o_total_probes,
    output logic [shpa_pkg::STATUS_W-1:0]   o_status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [shpa_pkg::APB_AW-1:0]     paddr,
    input  logic [shpa_pkg::APB_DW-1:0]     pwdata,
    output logic [shpa_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int FW   = shpa_pkg::FIELD_W;
    localparam int TW   = shpa_pkg::TOTAL_W;
    localparam int SW   = $clog2(SLOTS);
    localparam int KW   = $clog2(KEY_SPACE);
    localparam int SZW  = $clog2(SLOTS + 1);
    localparam int MAXD = (SLOTS > KEY_SPACE) ? SLOTS : KEY_SPACE;
    localparam int CW   = $clog2(MAXD);

    localparam int KEY_SH  = FW + $clog2(KEY_SPACE);
    localparam int KEY_MUL = ((1 << KEY_SH) + KEY_SPACE - 1) / KEY_SPACE;
    localparam logic [FW-1:0] KEY_LO = FW'(KEY_SPACE);

    shpa_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_clr, n_clr;
    logic                 r_op, n_op;
    logic [SW-1:0]        r_home, n_home;
    logic [SW-1:0]        r_stepm, n_stepm;
    logic [KW-1:0]        r_key, n_key;
    logic [FW-1:0]        r_kraw, n_kraw;
    logic [FW-1:0]        r_kquo, n_kquo;
    logic [SW-1:0]        r_pos, n_pos;
    logic [SW-1:0]        r_skip, n_skip;
    logic [TW-1:0]        r_total, n_total;
    logic                 r_o_valid, n_o_valid;
    logic [FW-1:0]        r_o_slot, n_o_slot;
    logic [FW-1:0]        r_o_skip, n_o_skip;
    shpa_pkg::t_status    r_o_status, n_o_status;

    logic [shpa_pkg::SIZE_W-1:0] table_size;
    logic [FW-1:0]        probe_step;
    logic [SZW-1:0]       eff_size;

    logic                 mod_start;
    logic                 home_done, step_done;
    logic [SZW-1:0]       home_rem, step_rem;

    logic [31:0]          key_prod;
    logic [FW-1:0]        key_quo;
    logic [FW-1:0]        key_low;
    logic [KW-1:0]        key_mod;

    shpa_pkg::t_store_ctl ctl;
    logic [SW-1:0]        occ_waddr, occ_raddr;
    logic                 occ_rdata;
    logic [KW-1:0]        key_waddr;
    logic [SW-1:0]        key_wslot;
    logic                 key_rpresent;
    logic [SW-1:0]        key_rslot;

    logic [SW:0]          pos_sum;
    logic [SW-1:0]        pos_nxt;
    logic [TW:0]          tot_sum;
    logic [TW-1:0]        tot_sat;

    shpa_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_table_size (table_size),
        .o_probe_step (probe_step)
    );

    always_comb begin
        if (table_size == '0) begin
            eff_size = SZW'(1);
        end else if (32'(table_size) > SLOTS) begin
            eff_size = SZW'(SLOTS);
        end else begin
            eff_size = SZW'(table_size);
        end
    end

    shpa_mod_unit #(.DW(FW), .VW(SZW)) u_home_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_home_slot),
        .i_divisor  (eff_size),
        .o_done     (home_done),
        .o_rem      (home_rem)
    );

    shpa_mod_unit #(.DW(FW), .VW(SZW)) u_step_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (probe_step),
        .i_divisor  (eff_size),
        .o_done     (step_done),
        .o_rem      (step_rem)
    );

    assign key_prod = 32'(i_key_id) * 32'(KEY_MUL);
    assign key_quo  = FW'(key_prod >> KEY_SH);
    assign key_low  = r_kraw - FW'(r_kquo * KEY_LO);
    assign key_mod  = KW'(key_low);

    shpa_store #(.SLOTS(SLOTS), .KEY_SPACE(KEY_SPACE)) u_store (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_occ_waddr    (occ_waddr),
        .i_occ_raddr    (occ_raddr),
        .o_occ_rdata    (occ_rdata),
        .i_key_waddr    (key_waddr),
        .i_key_raddr    (r_key),
        .i_key_wslot    (key_wslot),
        .o_key_rpresent (key_rpresent),
        .o_key_rslot    (key_rslot)
    );

    assign pos_sum = {1'b0, r_pos} + {1'b0, r_stepm};
    assign pos_nxt = (32'(pos_sum) >= 32'(eff_size))
                   ? SW'(pos_sum - (SW + 1)'(eff_size))
                   : pos_sum[SW-1:0];

    assign tot_sum = {1'b0, r_total} + (TW + 1)'(r_skip);
    assign tot_sat = tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_home     = r_home;
        n_stepm    = r_stepm;
        n_key      = r_key;
        n_kraw     = r_kraw;
        n_kquo     = r_kquo;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_total    = r_total;
        n_o_valid  = 1'b0;
        n_o_slot   = r_o_slot;
        n_o_skip   = r_o_skip;
        n_o_status = r_o_status;
        mod_start  = 1'b0;
        busy       = 1'b1;
        ctl        = '0;
        occ_waddr  = r_pos;
        key_waddr  = r_key;
        key_wslot  = r_pos;
        occ_raddr  = (r_state == shpa_pkg::ST_PROBE) ? pos_nxt : SW'(home_rem);

        case (r_state)
            shpa_pkg::ST_CLEAR: begin
                ctl.occ_we = (32'(r_clr) < SLOTS);
                ctl.key_we = (32'(r_clr) < KEY_SPACE);
                occ_waddr  = r_clr[SW-1:0];
                key_waddr  = r_clr[KW-1:0];
                n_clr      = r_clr + 1'b1;
                if (r_clr == CW'(MAXD - 1)) begin
                    n_state = shpa_pkg::ST_IDLE;
                end
            end
            shpa_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    mod_start = 1'b1;
                    n_op      = i_op;
                    n_kraw    = i_key_id;
                    n_kquo    = key_quo;
                    n_state   = shpa_pkg::ST_MOD;
                end
            end
            shpa_pkg::ST_MOD: begin
                n_key = key_mod;
                if (home_done && step_done) begin
                    n_home  = SW'(home_rem);
                    n_stepm = SW'(step_rem);
                    n_pos   = SW'(home_rem);
                    n_skip  = '0;
                    n_state = (r_op == shpa_pkg::OP_DELETE) ? shpa_pkg::ST_DEL
                                                            : shpa_pkg::ST_PROBE;
                end
            end
            shpa_pkg::ST_PROBE: begin
                if (!occ_rdata) begin
                    ctl.occ_we       = 1'b1;
                    ctl.occ_wbit     = 1'b1;
                    ctl.key_we       = 1'b1;
                    ctl.key_wpresent = 1'b1;
                    n_total          = tot_sat;
                    n_o_valid        = 1'b1;
                    n_o_slot         = FW'(r_pos);
                    n_o_skip         = FW'(r_skip);
                    n_o_status       = shpa_pkg::STAT_OK;
                    n_state          = shpa_pkg::ST_IDLE;
                end else if (pos_nxt == r_home) begin
                    n_o_valid  = 1'b1;
                    n_o_slot   = '0;
                    n_o_skip   = '0;
                    n_o_status = shpa_pkg::STAT_FULL;
                    n_state    = shpa_pkg::ST_IDLE;
                end else begin
                    n_pos  = pos_nxt;
                    n_skip = r_skip + 1'b1;
                end
            end
            shpa_pkg::ST_DEL: begin
                n_o_valid = 1'b1;
                n_o_skip  = '0;
                n_state   = shpa_pkg::ST_IDLE;
                occ_waddr = key_rslot;
                if (key_rpresent) begin
                    ctl.occ_we = 1'b1;
                    ctl.key_we = 1'b1;
                    n_o_slot   = FW'(key_rslot);
                    n_o_status = shpa_pkg::STAT_OK;
                end else begin
                    n_o_slot   = '0;
                    n_o_status = shpa_pkg::STAT_ABSENT;
                end
            end
            default: begin
                n_state = shpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= shpa_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
        end
        r_op       <= n_op;
        r_home     <= n_home;
        r_stepm    <= n_stepm;
        r_key      <= n_key;
        r_kraw     <= n_kraw;
        r_kquo     <= n_kquo;
        r_pos      <= n_pos;
        r_skip     <= n_skip;
        r_o_slot   <= n_o_slot;
        r_o_skip   <= n_o_skip;
        r_o_status <= n_o_status;
    end

    assign o_valid          = r_o_valid;
    assign o_slot           = r_o_slot;
    assign o_skipped_probes = r_o_skip;
    assign o_total_probes   = r_total;
    assign o_status         = r_o_status;

endmodule

@@ sim/tb_stepped_probe_hash_slot_allocator.sv @@
// Self-checking testbench for stepped_probe_hash_slot_allocator: directed and random
// insert/delete beats under several table sizes and probe steps, checked against a local model.
// Depends on shpa_pkg and the allocator RTL only.
module tb_stepped_probe_hash_slot_allocator;

    import shpa_pkg::*;

    localparam int SLOTS       = DEF_SLOTS;
    localparam int KEY_SPACE   = DEF_KEY_SPACE;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TAIL_CYCLES = 1100;
    localparam int PHASE_ITEMS = 125;

    localparam logic [APB_AW-1:0] ADDR_TABLE_SIZE = {REG_TABLE_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_PROBE_STEP = {REG_PROBE_STEP, 2'b00};
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] home;
    } t_alloc_cmd;

    typedef struct packed {
        logic [FIELD_W-1:0] slot;
        logic [FIELD_W-1:0] skipped;
        logic [TOTAL_W-1:0] total;
        t_status            status;
    } t_slot_beat;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                i_op        = OP_INSERT;
    logic [FIELD_W-1:0]  i_key_id    = '0;
    logic [FIELD_W-1:0]  i_home_slot = '0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic                busy;
    logic                o_valid;
    logic [FIELD_W-1:0]  o_slot;
    logic [FIELD_W-1:0]  o_skipped_probes;
    logic [TOTAL_W-1:0]  o_total_probes;
    logic [STATUS_W-1:0] o_status;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    t_alloc_cmd  cmd_q[$];
    t_slot_beat  expected_slots[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 1;
    int unsigned gap_left    = 0;
    t_alloc_cmd  cmd_next;
    t_slot_beat  beat_got;
    t_slot_beat  beat_want;

    // allocator state as predicted
    bit                 occ_map  [0:SLOTS-1];
    logic [FIELD_W-1:0] key_loc  [0:KEY_SPACE-1];
    bit                 key_live [0:KEY_SPACE-1];
    logic [TOTAL_W-1:0] probe_sum;
    logic [SIZE_W-1:0]  cfg_size;
    logic [FIELD_W-1:0] cfg_step;

    stepped_probe_hash_slot_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_key_id         (i_key_id),
        .i_home_slot      (i_home_slot),
        .o_valid          (o_valid),
        .o_slot           (o_slot),
        .o_skipped_probes (o_skipped_probes),
        .o_total_probes   (o_total_probes),
        .o_status         (o_status),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_slots();
        if (cfg_size == 0) return 1;
        if (cfg_size > SLOTS) return SLOTS;
        return cfg_size;
    endfunction

    task automatic alloc_predict(input logic op, input logic [FIELD_W-1:0] key,
                                 input logic [FIELD_W-1:0] home);
        int unsigned sz;
        int unsigned base;
        int unsigned stride;
        int unsigned pos;
        int unsigned hops;
        bit          hit;
        bit          done;
        t_slot_beat  b;
        sz = eff_slots();
        b = '0;
        if (op == OP_DELETE) begin
            if (!key_live[key]) begin
                b.status = STAT_ABSENT;
            end else begin
                occ_map[key_loc[key]] = 1'b0;
                key_live[key] = 1'b0;
                b.slot = key_loc[key];
                b.status = STAT_OK;
            end
        end else begin
            base = home % sz;
            stride = cfg_step % sz;
            pos = base;
            hops = 0;
            hit = 1'b0;
            done = 1'b0;
            while (!done) begin
                if (!occ_map[pos]) begin
                    hit = 1'b1;
                    done = 1'b1;
                end else begin
                    hops++;
                    pos = (pos + stride) % sz;
                    if (pos == base) done = 1'b1;
                end
            end
            if (!hit) begin
                b.status = STAT_FULL;
            end else begin
                occ_map[pos] = 1'b1;
                key_loc[key] = pos[FIELD_W-1:0];
                key_live[key] = 1'b1;
                if (TOTAL_SAT - probe_sum < hops) probe_sum = TOTAL_SAT;
                else probe_sum = probe_sum + hops;
                b.slot = pos[FIELD_W-1:0];
                b.skipped = hops[FIELD_W-1:0];
                b.status = STAT_OK;
            end
        end
        b.total = probe_sum;
        expected_slots.insert(expected_slots.size(), b);
    endtask

    // command driver: bursts with random gaps, hold start until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end else if (cmd_q.size() > 0) begin
                cmd_next = cmd_q.pop_front();
                start <= 1'b1;
                i_op <= cmd_next.op;
                i_key_id <= cmd_next.key;
                i_home_slot <= cmd_next.home;
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            foreach (key_live[i]) key_live[i] = 1'b0;
            foreach (key_loc[i]) key_loc[i] = '0;
            probe_sum = '0;
            cfg_size = RST_TABLE_SIZE;
            cfg_step = RST_PROBE_STEP;
        end else begin
            if (o_valid) begin
                beat_got = {o_slot, o_skipped_probes, o_total_probes, t_status'(o_status)};
                if (expected_slots.size() == 0) begin
                    $error("unexpected result beat: slot %0d status %0d", o_slot, o_status);
                    fail_count++;
                end else begin
                    beat_want = expected_slots.pop_front();
                    if (beat_got.slot !== beat_want.slot) begin
                        $error("slot: expected %0d, got %0d", beat_want.slot, beat_got.slot);
                        fail_count++;
                    end
                    if (beat_got.skipped !== beat_want.skipped) begin
                        $error("skipped_probes: expected %0d, got %0d",
                               beat_want.skipped, beat_got.skipped);
                        fail_count++;
                    end
                    if (beat_got.total !== beat_want.total) begin
                        $error("total_probes: expected %0d, got %0d",
                               beat_want.total, beat_got.total);
                        fail_count++;
                    end
                    if (beat_got.status !== beat_want.status) begin
                        $error("status: expected %0d, got %0d",
                               beat_want.status, beat_got.status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) alloc_predict(i_op, i_key_id, i_home_slot);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(input logic op, input int unsigned key, input int unsigned home);
        cmd_q.insert(cmd_q.size(), '{op, key[FIELD_W-1:0], home[FIELD_W-1:0]});
    endtask

    task automatic drain();
        wait (cmd_q.size() == 0 && !start && expected_slots.size() == 0);
        @(posedge i_clk);
        wait (!busy);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_TABLE_SIZE) cfg_size = data[SIZE_W-1:0];
        else cfg_step = data[FIELD_W-1:0];
    endtask

    task automatic set_cfg(input int unsigned size, input int unsigned step);
        drain();
        apb_write(ADDR_TABLE_SIZE, size);
        apb_write(ADDR_PROBE_STEP, step);
    endtask

    // mostly inserts of fresh keys and deletes of live ones, some noise
    task automatic queue_phase(input int unsigned n);
        int unsigned live[$];
        bit          gen_live [0:KEY_SPACE-1];
        int unsigned r;
        int unsigned idx;
        int unsigned key;
        int unsigned tries;
        bit          crowded;
        foreach (key_live[k]) begin
            gen_live[k] = key_live[k];
            if (key_live[k]) live.insert(live.size(), k);
        end
        repeat (n) begin
            r = $urandom_range(0, 99);
            crowded = (live.size() >= eff_slots());
            if (r < 8) begin
                push_cmd($urandom_range(0, 1), $urandom_range(0, KEY_SPACE - 1),
                         $urandom_range(0, SLOTS - 1));
            end else if (live.size() > 0 && r < (crowded ? 65 : 40)) begin
                idx = $urandom_range(0, live.size() - 1);
                key = live[idx];
                live.delete(idx);
                gen_live[key] = 1'b0;
                push_cmd(OP_DELETE, key, $urandom_range(0, SLOTS - 1));
            end else begin
                tries = 0;
                do begin
                    key = $urandom_range(0, KEY_SPACE - 1);
                    tries++;
                end while (gen_live[key] && tries < 8);
                if (!gen_live[key]) live.insert(live.size(), key);
                gen_live[key] = 1'b1;
                push_cmd(OP_INSERT, key, $urandom_range(0, SLOTS - 1));
            end
        end
    endtask

    initial begin
        int unsigned phase_size [13] = '{2, 7, 16, 0, 1, 5, 33, 64, 128, 512, 1000, 2047, 1024};
        int unsigned phase_step [13] = '{1, 3, 4, 9, 1023, 10, 1023, 64, 96, 1, 999, 1023, 1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        wait (!busy);

        // default size and step: plain hits, collisions, wraparound, rekey, absent deletes
        push_cmd(OP_INSERT, 0, 0);
        push_cmd(OP_INSERT, 1023, 1023);
        push_cmd(OP_INSERT, 1, 0);
        push_cmd(OP_INSERT, 2, 1023);
        push_cmd(OP_INSERT, 1, 5);
        push_cmd(OP_DELETE, 1, 0);
        push_cmd(OP_DELETE, 1, 1023);
        push_cmd(OP_DELETE, 500, 0);
        push_cmd(OP_DELETE, 0, 0);
        push_cmd(OP_INSERT, 3, 1023);

        // single-slot table with step a multiple of the size
        set_cfg(1, 1023);
        push_cmd(OP_INSERT, 10, 1023);
        push_cmd(OP_DELETE, 3, 0);
        push_cmd(OP_INSERT, 10, 1023);
        push_cmd(OP_INSERT, 11, 0);

        // size zero acts as one slot
        set_cfg(0, 1023);
        push_cmd(OP_INSERT, 12, 7);
        push_cmd(OP_DELETE, 10, 0);
        push_cmd(OP_INSERT, 12, 7);

        // oversize table, step reaching only two slots
        set_cfg(2047, 512);
        push_cmd(OP_INSERT, 20, 1023);
        push_cmd(OP_INSERT, 21, 511);
        push_cmd(OP_DELETE, 20, 0);
        push_cmd(OP_DELETE, 21, 0);
        push_cmd(OP_DELETE, 1023, 0);

        foreach (phase_size[p]) begin
            set_cfg(phase_size[p], phase_step[p]);
            queue_phase(PHASE_ITEMS);
        end
        repeat (3) begin
            set_cfg($urandom_range(1, SLOTS), $urandom_range(1, SLOTS - 1));
            queue_phase(PHASE_ITEMS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_slots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
